// ----- hw/rtl/nmtl_pkg.sv -----
package nmtl_pkg;

	localparam int TYPE_COUNT_DEF = 16;
	localparam int TILE_BITS_DEF  = 16;
	localparam int APB_ADDR_W     = 4;

	localparam logic [1:0] FUNC_CELL = 2'd0;
	localparam logic [1:0] FUNC_ADD  = 2'd1;
	localparam logic [1:0] FUNC_CONN = 2'd2;

	localparam logic [1:0] REG_NUM_TYPES  = 2'd0;
	localparam logic [1:0] REG_OFF_GRID   = 2'd1;
	localparam logic [1:0] REG_GLOBAL_DEF = 2'd2;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_LOOK  = 5'b00100,
		ST_RESP  = 5'b01000,
		ST_WALK  = 5'b10000
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

// ----- hw/rtl/nmtl_case_mem.sv -----
module nmtl_case_mem
	import nmtl_pkg::*;
#(
	parameter int DEPTH  = TYPE_COUNT_DEF * 256,
	parameter int ADDR_W = $clog2(TYPE_COUNT_DEF) + 8,
	parameter int DATA_W = TILE_BITS_DEF + 1
) (
	input  logic              clk,
	input  mem_ctl_t          ctl,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/neighbor_mask_tile_lookup.sv -----
// Eight-neighbor autotile lookup. A cell transfer (func 0) is taken when start is high and
// busy is low; its tile appears on tile_value with result_valid high for exactly one cycle,
// after the look state (pattern build, case table read), in the response state, and busy
// drops once that state is left, so a new cell is taken only after the last one's result.
// There is no way to hold a result off: the receiver must take it in the cycle it is shown.
// A connection bitmap write, a type default write (case_care of zero) and func 3 complete
// in the transfer cycle and leave busy low. An add-case transfer with a nonzero care mask
// walks all 256 patterns of the type through one compare and write step per cycle with busy
// high. After reset the case table is swept clear one entry per cycle, all TYPE_COUNT*256
// entries (4096 by default), with busy high; register writes on the APB port are taken at
// any time but must only change while the block is idle.
module neighbor_mask_tile_lookup
	import nmtl_pkg::*;
#(
	parameter int TYPE_COUNT = TYPE_COUNT_DEF,
	parameter int TILE_BITS  = TILE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            func,
	input  logic [3:0]            center_type,
	input  logic [31:0]           neighbor_types,
	input  logic [7:0]            outside_mask,
	input  logic [3:0]            case_type,
	input  logic [7:0]            case_pattern,
	input  logic [7:0]            case_care,
	input  logic [15:0]           case_value,
	input  logic [15:0]           connect_bits,
	output logic                  result_valid,
	output logic [15:0]           tile_value
);

	localparam int TYPE_W = $clog2(TYPE_COUNT);
	localparam int ADDR_W = TYPE_W + 8;
	localparam int DEPTH  = TYPE_COUNT * 256;
	localparam int DATA_W = TILE_BITS + 1;

	state_t state_q;
	logic [ADDR_W-1:0] ptr_q;

	logic [4:0]  num_types_q;
	logic [3:0]  off_grid_q;
	logic [15:0] global_def_q;

	logic [15:0]          connect_map_q  [TYPE_COUNT];
	logic [TILE_BITS-1:0] type_default_q [TYPE_COUNT];

	logic [3:0]           ctype_q;
	logic [31:0]          ntypes_q;
	logic [7:0]           outside_q;
	logic [7:0]           pat_q;
	logic [7:0]           care_q;
	logic [TILE_BITS-1:0] value_q;
	logic                 glob_q;
	logic [TILE_BITS-1:0] dflt_q;

	logic                 accept;
	logic                 cfg_wr;
	logic                 ktype_ok;
	logic [TYPE_W-1:0]    kidx;
	logic [TYPE_W-1:0]    cidx;
	logic [7:0]           cell_pat;
	logic                 walk_hit;
	mem_ctl_t             mem_ctl;
	logic [ADDR_W-1:0]    mem_raddr;
	logic [DATA_W-1:0]    mem_wdata;
	logic [DATA_W-1:0]    mem_rdata;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign ktype_ok = ({28'd0, case_type} < 32'(TYPE_COUNT));
	assign kidx     = TYPE_W'(case_type);
	assign cidx     = TYPE_W'(ctype_q);

	always_comb begin
		logic [3:0]  nt;
		logic [15:0] conn;
		nt   = '0;
		conn = connect_map_q[cidx];
		cell_pat = '0;
		for (int i = 0; i < 8; i++) begin
			nt = outside_q[i] ? off_grid_q : ntypes_q[4*i +: 4];
			cell_pat[7-i] = conn[nt];
		end
	end

	// pattern compare for the case walk
	assign walk_hit = (((ptr_q[7:0] ^ pat_q) & care_q) == 8'd0);

	assign mem_ctl.wr_en = (state_q == ST_CLEAR) || ((state_q == ST_WALK) && walk_hit);
	assign mem_ctl.rd_en = (state_q == ST_LOOK);
	assign mem_raddr     = {cidx, cell_pat};
	assign mem_wdata     = (state_q == ST_CLEAR) ? '0 : {1'b1, value_q};

	nmtl_case_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (DATA_W)
	) u_case_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (ptr_q),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			ptr_q        <= '0;
			num_types_q  <= '0;
			off_grid_q   <= '0;
			global_def_q <= '0;
			for (int t = 0; t < TYPE_COUNT; t++) begin
				connect_map_q[t]  <= '0;
				type_default_q[t] <= '0;
			end
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_NUM_TYPES:  num_types_q  <= pwdata[4:0];
					REG_OFF_GRID:   off_grid_q   <= pwdata[3:0];
					REG_GLOBAL_DEF: global_def_q <= pwdata[15:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_CELL: state_q <= ST_LOOK;
							FUNC_ADD: begin
								if (ktype_ok) begin
									if (case_care == 8'd0) begin
										type_default_q[kidx] <= TILE_BITS'(case_value);
									end else begin
										ptr_q   <= {kidx, 8'd0};
										state_q <= ST_WALK;
									end
								end
							end
							FUNC_CONN: begin
								if (ktype_ok) begin
									connect_map_q[kidx] <= connect_bits;
								end
							end
							default: ;
						endcase
					end
				end
				ST_LOOK: state_q <= ST_RESP;
				ST_RESP: state_q <= ST_IDLE;
				ST_WALK: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q[7:0] == 8'hff) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctype_q   <= center_type;
			ntypes_q  <= neighbor_types;
			outside_q <= outside_mask;
			pat_q     <= case_pattern;
			care_q    <= case_care;
			value_q   <= TILE_BITS'(case_value);
		end
		if (state_q == ST_LOOK) begin
			glob_q <= ({1'b0, ctype_q} >= num_types_q) || ({28'd0, ctype_q} >= 32'(TYPE_COUNT));
			dflt_q <= type_default_q[cidx];
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_NUM_TYPES:  prdata = {27'd0, num_types_q};
			REG_OFF_GRID:   prdata = {28'd0, off_grid_q};
			REG_GLOBAL_DEF: prdata = {16'd0, global_def_q};
			default:        prdata = '0;
		endcase
	end

	assign result_valid = (state_q == ST_RESP);

	always_comb begin
		if (glob_q) begin
			tile_value = global_def_q;
		end else if (mem_rdata[TILE_BITS]) begin
			tile_value = 16'(mem_rdata[TILE_BITS-1:0]);
		end else begin
			tile_value = 16'(dflt_q);
		end
	end

endmodule

// ----- hw/rtl/nmtl_checker.sv -----
module nmtl_checker
	import nmtl_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  func,
	input logic        result_valid,
	input logic        pready
);

	// cell transfer gives its tile after the look and response states
	a_cell_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FUNC_CELL) |-> ##2 result_valid)
		else $error("cell transfer without result");

	a_cell_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FUNC_CELL) |=> busy)
		else $error("busy low after cell transfer");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (busy && pready))
		else $error("result shown while idle");

endmodule

bind neighbor_mask_tile_lookup nmtl_checker u_nmtl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.func         (func),
	.result_valid (result_valid),
	.pready       (pready)
);
